// File: design/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants of the framed command receiver: register
// indexes, reset values, parser phases and the result item layout.
// ----------------------------------------------------------------------------
package fcr_pkg;

   // field widths
   localparam int unsigned ByteW   = 8;
   localparam int unsigned PosW    = 6;
   localparam int unsigned LenW    = 7;
   localparam int unsigned CsrIdxW = 3;

   // buffer depth default and the hard ceiling set by the 6-bit position
   localparam int unsigned BufDepthDef = 64;
   localparam int unsigned PosCeiling  = 64;

   // smallest legal total frame length
   localparam logic [LenW-1:0] MinFrameLen = LenW'(4);

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrHeadByte   = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrTailByte   = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CsrMaxLen     = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] CsrFirstCmd   = CsrIdxW'(3);
   localparam logic [CsrIdxW-1:0] CsrSecondCmd  = CsrIdxW'(4);

   // register reset values
   localparam logic [LenW-1:0] MaxLenReset = LenW'(48);

   // parser phases, one-hot
   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_CMD  = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   // configuration registers as seen by the parser
   typedef struct packed {
      logic [ByteW-1:0] head_byte;
      logic [ByteW-1:0] tail_byte;
      logic [LenW-1:0]  max_frame_len;
      logic [ByteW-1:0] first_cmd_code;
      logic [ByteW-1:0] second_cmd_code;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [ByteW-1:0] byte_value;
      logic [PosW-1:0]  byte_index;
      logic             stored;
      logic             cmd_select;
      logic             frame_done;
      logic             frame_abort;
   } result_type;

endpackage

// File: design/fcr_csr.sv
// ----------------------------------------------------------------------------
// fcr_csr
// Configuration register file: five write-only registers behind a plain
// write port, writes to indexes past the list are dropped.
// ----------------------------------------------------------------------------
module fcr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [fcr_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [fcr_pkg::ByteW-1:0]       csr_wdata,
   output fcr_pkg::cfg_type                cfg
);

   fcr_pkg::cfg_type cfg_ff;
   fcr_pkg::cfg_type cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            fcr_pkg::CsrHeadByte:  cfg_in.head_byte       = csr_wdata;
            fcr_pkg::CsrTailByte:  cfg_in.tail_byte       = csr_wdata;
            fcr_pkg::CsrMaxLen:    cfg_in.max_frame_len   = csr_wdata[fcr_pkg::LenW-1:0];
            fcr_pkg::CsrFirstCmd:  cfg_in.first_cmd_code  = csr_wdata;
            fcr_pkg::CsrSecondCmd: cfg_in.second_cmd_code = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte       <= '0;
         cfg_ff.tail_byte       <= '0;
         cfg_ff.max_frame_len   <= fcr_pkg::MaxLenReset;
         cfg_ff.first_cmd_code  <= '0;
         cfg_ff.second_cmd_code <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/fcr_parser.sv
// ----------------------------------------------------------------------------
// fcr_parser
// Frame state machine: holds phase, position, remaining count and command
// kind, and forms the result item for the incoming byte in one pass.
// ----------------------------------------------------------------------------
module fcr_parser #(
   parameter int unsigned BUF_DEPTH = fcr_pkg::BufDepthDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_accept,
   input  logic [fcr_pkg::ByteW-1:0]   rx_byte,
   input  fcr_pkg::cfg_type            cfg,
   output fcr_pkg::result_type         result
);

   // length ceiling from the buffer depth and the position width
   localparam int unsigned LenCap = (BUF_DEPTH < fcr_pkg::PosCeiling) ?
                                    BUF_DEPTH : fcr_pkg::PosCeiling;

   fcr_pkg::phase_type              phase_ff, phase_in;
   logic [fcr_pkg::PosW-1:0]        position_ff, position_in;
   logic [fcr_pkg::LenW-1:0]        remaining_ff, remaining_in;
   logic                            cmd_kind_ff, cmd_kind_in;

   logic [fcr_pkg::LenW-1:0]        len_limit;
   logic                            len_ok;
   logic                            first_hit;
   logic                            second_hit;
   logic [fcr_pkg::PosW-1:0]        position_inc;

   // effective length limit
   always_comb begin
      if (cfg.max_frame_len > fcr_pkg::LenW'(LenCap)) begin
         len_limit = fcr_pkg::LenW'(LenCap);
      end else begin
         len_limit = cfg.max_frame_len;
      end
   end

   assign len_ok = (rx_byte >= fcr_pkg::ByteW'(fcr_pkg::MinFrameLen)) &&
                   (rx_byte <= fcr_pkg::ByteW'(len_limit));
   assign first_hit    = (rx_byte == cfg.first_cmd_code);
   assign second_hit   = (rx_byte == cfg.second_cmd_code);
   assign position_inc = position_ff + fcr_pkg::PosW'(1);

   // next state and result item
   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      remaining_in = remaining_ff;
      cmd_kind_in  = cmd_kind_ff;
      result.byte_value  = rx_byte;
      result.byte_index  = position_ff;
      result.stored      = 1'b0;
      result.cmd_select  = 1'b0;
      result.frame_done  = 1'b0;
      result.frame_abort = 1'b0;
      case (phase_ff)
         fcr_pkg::PH_HUNT: begin
            result.byte_index = '0;
            if (rx_byte == cfg.head_byte) begin
               result.stored = 1'b1;
               position_in   = fcr_pkg::PosW'(1);
               phase_in      = fcr_pkg::PH_LEN;
            end
         end
         fcr_pkg::PH_LEN: begin
            if (len_ok) begin
               result.stored = 1'b1;
               remaining_in  = rx_byte[fcr_pkg::LenW-1:0] - fcr_pkg::LenW'(2);
               position_in   = position_inc;
               phase_in      = fcr_pkg::PH_CMD;
            end else begin
               result.frame_abort = 1'b1;
               phase_in     = fcr_pkg::PH_HUNT;
               position_in  = '0;
               remaining_in = '0;
            end
         end
         fcr_pkg::PH_CMD: begin
            if (first_hit || second_hit) begin
               result.stored     = 1'b1;
               cmd_kind_in       = !first_hit;
               result.cmd_select = !first_hit;
               remaining_in      = remaining_ff - fcr_pkg::LenW'(1);
               position_in       = position_inc;
               phase_in          = fcr_pkg::PH_DATA;
            end else begin
               result.frame_abort = 1'b1;
               phase_in     = fcr_pkg::PH_HUNT;
               position_in  = '0;
               remaining_in = '0;
            end
         end
         fcr_pkg::PH_DATA: begin
            if (remaining_ff > fcr_pkg::LenW'(1)) begin
               result.stored     = 1'b1;
               result.cmd_select = cmd_kind_ff;
               remaining_in      = remaining_ff - fcr_pkg::LenW'(1);
               position_in       = position_inc;
            end else begin
               // closing byte: tail completes the frame, anything else drops it
               if (rx_byte == cfg.tail_byte) begin
                  result.stored     = 1'b1;
                  result.cmd_select = cmd_kind_ff;
                  result.frame_done = 1'b1;
               end else begin
                  result.frame_abort = 1'b1;
               end
               phase_in     = fcr_pkg::PH_HUNT;
               position_in  = '0;
               remaining_in = '0;
            end
         end
         default: begin
            phase_in     = fcr_pkg::PH_HUNT;
            position_in  = '0;
            remaining_in = '0;
         end
      endcase
   end

   // state registers, updated per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fcr_pkg::PH_HUNT;
         position_ff  <= '0;
         remaining_ff <= '0;
         cmd_kind_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         remaining_ff <= remaining_in;
         cmd_kind_ff  <= cmd_kind_in;
      end
   end

   // a byte never both completes and drops a frame
   a_done_abort_excl: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(result.frame_done && result.frame_abort))
      else $error("frame done and abort on the same item");

   // completed or dropped frame sends the parser back to hunting
   a_back_to_hunt: assert property (@(posedge clock) disable iff (reset)
      req_accept && (result.frame_done || result.frame_abort)
      |=> (phase_ff == fcr_pkg::PH_HUNT) && (position_ff == '0))
      else $error("parser did not return to hunting");

   // inside a frame the position is never zero
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != fcr_pkg::PH_HUNT) |-> (position_ff != '0))
      else $error("zero position inside a frame");

   // data phase always has a byte left to take
   a_data_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == fcr_pkg::PH_DATA) |-> (remaining_ff != '0))
      else $error("data phase with nothing remaining");

endmodule

// File: design/fcr_out_buf.sv
// ----------------------------------------------------------------------------
// fcr_out_buf
// Result register with one skid entry, so a new item is taken while the
// current result still waits on the downstream stall.
// ----------------------------------------------------------------------------
module fcr_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fcr_pkg::result_type   push_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output fcr_pkg::result_type   rsp_data,
   output logic                  full
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   fcr_pkg::result_type  out_data_ff, out_data_in;
   fcr_pkg::result_type  skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop = out_valid_ff && !rsp_stall;

   // refill from skid on pop, then place the new item
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_in) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

   // skid entry only holds an item behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry filled with empty result register");

   // an item is never pushed into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("item pushed into full output buffer");

   // a stalled result with an item behind it fills the skid entry
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid entry not filled under stall");

endmodule

// File: design/framed_command_receiver_top.sv
// Each accepted byte's result item is registered, in the skid entry if a result waits.
// Throughput: one byte per cycle while req_stall is low; state update is a single compare-and-count pass.
// A one-entry skid behind the result register keeps intake going for one extra item
// while the result side stalls; req_stall rises only when that skid entry is occupied.
// Reset (synchronous, active high): parser hunts for a head, buffer empty, registers
// back to defaults (max_frame_len 48, all byte codes 0).
// ----------------------------------------------------------------------------
// framed_command_receiver_top
// Byte-stream frame parser: head, length, command, data and tail bytes,
// with one result item per received byte.
// ----------------------------------------------------------------------------
module framed_command_receiver_top #(
   parameter int unsigned BUF_DEPTH = fcr_pkg::BufDepthDef
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_en,
   input  logic [fcr_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [fcr_pkg::ByteW-1:0]       csr_wdata,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fcr_pkg::ByteW-1:0]       req_rx_byte,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fcr_pkg::ByteW-1:0]       rsp_byte_value,
   output logic [fcr_pkg::PosW-1:0]        rsp_byte_index,
   output logic                            rsp_stored,
   output logic                            rsp_cmd_select,
   output logic                            rsp_frame_done,
   output logic                            rsp_frame_abort
);

   fcr_pkg::cfg_type     cfg;
   fcr_pkg::result_type  result;
   fcr_pkg::result_type  rsp_data;
   logic                 req_accept;
   logic                 buf_full;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   // configuration registers
   fcr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // frame state machine
   fcr_parser #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg),
      .result     (result)
   );

   // result register and skid entry
   fcr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (buf_full)
   );

   assign rsp_byte_value  = rsp_data.byte_value;
   assign rsp_byte_index  = rsp_data.byte_index;
   assign rsp_stored      = rsp_data.stored;
   assign rsp_cmd_select  = rsp_data.cmd_select;
   assign rsp_frame_done  = rsp_data.frame_done;
   assign rsp_frame_abort = rsp_data.frame_abort;

endmodule
